// File: rtl/dbd_pkg.sv
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared widths, constants, command/status types and the month length table
// for the date stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dbd_pkg;

  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;

  // reset value of the step limit register
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 22'd4000000;

  // year mod 25 by reciprocal: q = (y * K) >> S underestimates by at most one
  localparam int MOD_K_W = 15;
  localparam logic [MOD_K_W-1:0] MOD25_K = 15'd20971;
  localparam int MOD25_SHIFT = 19;
  localparam int PROD_W = YEAR_W + MOD_K_W;
  localparam int QUOT_W = PROD_W - MOD25_SHIFT;
  localparam logic [4:0] MOD25_LAST = 5'd24;
  localparam logic [YEAR_W:0] MOD25_DIV = 15'd25;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch ordered dates, clear the count
    logic mul;       // register year times reciprocal
    logic modr;      // finish year mod 25
    logic step;      // advance one day
    logic out_load;  // capture the result
  } dbd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic finish;    // target reached or limit used up
  } dbd_status_t;

  // days in a month, out-of-range months are 31 long
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/dbd_datapath.sv
// ----------------------------------------------------------------------------
// dbd_datapath
// Working date, target date, step counter, leap tracking and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbd_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  dbd_pkg::dbd_cmd_t      cmd,
  output dbd_pkg::dbd_status_t   status,
  input  logic                   cfg_write,
  input  logic [21:0]            cfg_data,
  input  logic [3:0]             start_month,
  input  logic [4:0]             start_day,
  input  logic [13:0]            start_year,
  input  logic [3:0]             end_month,
  input  logic [4:0]             end_day,
  input  logic [13:0]            end_year,
  output logic [21:0]            day_count,
  output logic                   backwards,
  output logic                   limit_hit
);
  import dbd_pkg::*;

  logic [COUNT_W-1:0] step_limit;
  logic [DAY_W-1:0]   walk_day;
  logic [MONTH_W-1:0] walk_month;
  logic [YEAR_W-1:0]  walk_year;
  logic [COUNT_W-1:0] step_counter;
  logic [DAY_W-1:0]   tgt_day;
  logic [MONTH_W-1:0] tgt_month;
  logic [YEAR_W-1:0]  tgt_year;
  logic               back;
  logic [PROD_W-1:0]  prod;
  logic [4:0]         r25;

  logic               swap;
  logic               reached;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic [QUOT_W-1:0]  quot;
  logic [YEAR_W:0]    q25;
  logic [YEAR_W:0]    rem;
  logic [YEAR_W:0]    rem_fix;

  // order of the two dates as (year, month, day)
  assign swap = {end_year, end_month, end_day} < {start_year, start_month, start_day};

  assign reached = (walk_day == tgt_day) && (walk_month == tgt_month) &&
                   (walk_year == tgt_year);
  assign status.finish = reached || (step_counter >= step_limit);

  // gregorian leap: div by 4, and centuries only when div by 16 too
  assign leap = (walk_year[1:0] == 2'b00) && ((r25 != 5'd0) || (walk_year[3:0] == 4'd0));
  assign len  = month_length(walk_month, leap);

  // remainder of year by 25 from the registered product
  assign quot    = prod[PROD_W-1:MOD25_SHIFT];
  assign q25     = ({{(YEAR_W+1-QUOT_W){1'b0}}, quot} << 4) +
                   ({{(YEAR_W+1-QUOT_W){1'b0}}, quot} << 3) +
                   {{(YEAR_W+1-QUOT_W){1'b0}}, quot};
  assign rem     = {1'b0, walk_year} - q25;
  assign rem_fix = (rem >= MOD25_DIV) ? rem - MOD25_DIV : rem;

  // step limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      step_limit <= cfg_data;
    end
  end

  // working date and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_day     <= DAY_FIRST;
      walk_month   <= MONTH_JAN;
      walk_year    <= '0;
      step_counter <= '0;
      r25          <= '0;
    end else if (cmd.load) begin
      walk_day     <= swap ? end_day   : start_day;
      walk_month   <= swap ? end_month : start_month;
      walk_year    <= swap ? end_year  : start_year;
      step_counter <= '0;
    end else if (cmd.modr) begin
      r25 <= rem_fix[4:0];
    end else if (cmd.step) begin
      step_counter <= step_counter + 1'b1;
      if (walk_day < len) begin
        walk_day <= walk_day + 1'b1;
      end else begin
        walk_day <= DAY_FIRST;
        if (walk_month >= MONTH_DEC) begin
          walk_month <= MONTH_JAN;
          walk_year  <= walk_year + 1'b1;
          // year wrap lands on zero, which is 0 mod 25
          if ((&walk_year) || (r25 == MOD25_LAST)) begin
            r25 <= '0;
          end else begin
            r25 <= r25 + 1'b1;
          end
        end else begin
          walk_month <= walk_month + 1'b1;
        end
      end
    end
  end

  // target date, direction and reciprocal product
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_day   <= swap ? start_day   : end_day;
      tgt_month <= swap ? start_month : end_month;
      tgt_year  <= swap ? start_year  : end_year;
      back      <= swap;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(walk_year) * PROD_W'(MOD25_K);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      day_count <= step_counter;
      backwards <= back;
      limit_hit <= !reached;
    end
  end

  a_step_below_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> step_counter < step_limit)
    else $error("day step taken with limit used up");

  a_step_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> step_counter == $past(step_counter) + 1'b1)
    else $error("step counter did not advance");

  a_r25_range: assert property (@(posedge clk) disable iff (rst)
    r25 <= MOD25_LAST)
    else $error("year mod 25 out of range");

  a_day_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> walk_day != 5'd0)
    else $error("day zero after a step");

endmodule

// File: rtl/dbd_controller.sv
// ----------------------------------------------------------------------------
// dbd_controller
// Sequencer: accept a request, prepare leap tracking, walk days, deliver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbd_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  dbd_pkg::dbd_status_t   status,
  output dbd_pkg::dbd_cmd_t      cmd
);
  import dbd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        cmd.modr   = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (status.finish) begin
          state_next = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

  a_load_safe: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result overwritten before taken");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && status.finish) |=> state == ST_DONE)
    else $error("walk did not end on finish");

endmodule

// File: rtl/days_between_dates_stepper_top.sv
// ----------------------------------------------------------------------------
// days_between_dates_stepper_top
// Days between two Gregorian dates, counted one day step per clock.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   start_*, end_* dates
//   out      from block out_valid / out_stall day_count, backwards, limit_hit
//   cfg      to block   cfg_write             cfg_data (step limit)
//
// a request walks N days, N at most the step limit;
// the walk loop advances the working date one day each cycle.
// synchronous reset sets the step limit to 4000000 and leaves the block idle.
// a waiting result does not block the next request; only the final
// hand-over waits while a previous result is still stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module days_between_dates_stepper_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [21:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  start_month,
  input  logic [4:0]  start_day,
  input  logic [13:0] start_year,
  input  logic [3:0]  end_month,
  input  logic [4:0]  end_day,
  input  logic [13:0] end_year,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [21:0] day_count,
  output logic        backwards,
  output logic        limit_hit
);
  import dbd_pkg::*;

  dbd_cmd_t    cmd;
  dbd_status_t status;

  // sequencer
  dbd_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // date walk and result
  dbd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .start_month (start_month),
    .start_day   (start_day),
    .start_year  (start_year),
    .end_month   (end_month),
    .end_day     (end_day),
    .end_year    (end_year),
    .day_count   (day_count),
    .backwards   (backwards),
    .limit_hit   (limit_hit)
  );

endmodule
